@@ hdl/assert_macros.svh @@
// assertion macros for the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hdl/rv32m_pkg.sv @@
// types and constants for the rv32m multiply/divide unit
// no dependencies
package rv32m_pkg;
  localparam int Xlen = 32;
  localparam int QDepth = 2;

  typedef enum logic [2:0] {
    OP_MUL = 3'd0, OP_MULH = 3'd1, OP_MULHSU = 3'd2, OP_MULHU = 3'd3,
    OP_DIV = 3'd4, OP_DIVU = 3'd5, OP_REM = 3'd6, OP_REMU = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0, ST_MUL = 2'd1, ST_DIV = 2'd2, ST_DONE = 2'd3
  } state_t;

  // classified word passed from front to back
  typedef struct packed {
    logic              is_div;
    logic              hi_half;
    logic              is_rem;
    logic              a_signed;
    logic              b_signed;
    logic [Xlen-1:0]   a;
    logic [Xlen-1:0]   b;
  } cmd_t;
endpackage

@@ hdl/rv32m_front.sv @@
// front: accepts a word, classifies it and pushes it into a short queue
// depends on rv32m_pkg
module rv32m_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [2:0]                 func,
  input  logic [rv32m_pkg::Xlen-1:0] operand_a,
  input  logic [rv32m_pkg::Xlen-1:0] operand_b,
  output logic                       busy,
  input  logic                       pop,
  output logic                       q_valid,
  output rv32m_pkg::cmd_t            q_head
);
  import rv32m_pkg::*;

  cmd_t      slots [QDepth];
  logic [1:0] count;
  logic       rd_ptr, wr_ptr;
  cmd_t       cmd;
  logic       push;
  op_t        op;

  assign op = op_t'(func);
  always_comb begin
    cmd.a = operand_a;
    cmd.b = operand_b;
    cmd.is_div = func[2];
    cmd.is_rem = (op == OP_REM) || (op == OP_REMU);
    cmd.hi_half = (op != OP_MUL);
    cmd.a_signed = (op == OP_MULH) || (op == OP_MULHSU) || (op == OP_DIV) ||
                   (op == OP_REM);
    cmd.b_signed = (op == OP_MULH) || (op == OP_DIV) || (op == OP_REM);
  end

  assign busy = (count == 2'(QDepth));
  assign push = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd;
    end
    if (rst) begin
      count <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ hdl/rv32m_back.sv @@
// back: multiply through the ST_MUL and ST_DONE states, divide one quotient bit a cycle
// depends on rv32m_pkg
module rv32m_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  rv32m_pkg::cmd_t            q_head,
  output logic                       pop,
  output logic                       done,
  output logic [rv32m_pkg::Xlen-1:0] result
);
  import rv32m_pkg::*;

  state_t state, state_next;
  cmd_t   cur;
  logic [2*Xlen+1:0] prod;
  logic [Xlen-1:0] quo, rem, dvs;
  logic [5:0] cnt;
  logic neg_q, neg_r, dz, ovf;
  logic [Xlen-1:0] res_w;
  logic [Xlen:0] sa, sb;
  logic [Xlen:0] trial;
  logic [Xlen-1:0] ma, mb;

  assign sa = {cur.a_signed & cur.a[Xlen-1], cur.a};
  assign sb = {cur.b_signed & cur.b[Xlen-1], cur.b};
  assign ma = (q_head.a_signed && q_head.a[Xlen-1]) ? -q_head.a : q_head.a;
  assign mb = (q_head.b_signed && q_head.b[Xlen-1]) ? -q_head.b : q_head.b;
  assign trial = {rem, quo[Xlen-1]} - {1'b0, dvs};

  always_comb begin
    state_next = state;
    pop = 1'b0;
    case (state)
      ST_IDLE: if (q_valid) begin
        pop = 1'b1;
        state_next = q_head.is_div ? ST_DIV : ST_MUL;
      end
      ST_MUL: state_next = ST_DONE;
      ST_DIV: if (cnt == 6'(Xlen - 1)) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (!cur.is_div) res_w = cur.hi_half ? prod[2*Xlen-1:Xlen] : prod[Xlen-1:0];
    else if (cur.is_rem) res_w = dz ? cur.a : ovf ? '0 : (neg_r ? -rem : rem);
    else res_w = dz ? '1 : ovf ? {1'b1, {(Xlen-1){1'b0}}} : (neg_q ? -quo : quo);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
      quo <= ma;
      dvs <= mb;
      rem <= '0;
      cnt <= '0;
      dz <= (q_head.b == '0);
      ovf <= q_head.a_signed && (q_head.a == {1'b1, {(Xlen-1){1'b0}}}) && (q_head.b == '1);
      neg_q <= q_head.a_signed && (q_head.a[Xlen-1] ^ q_head.b[Xlen-1]);
      neg_r <= q_head.a_signed && q_head.a[Xlen-1];
    end else if (state == ST_DIV) begin
      cnt <= cnt + 6'd1;
      if (!trial[Xlen]) begin
        rem <= trial[Xlen-1:0];
        quo <= {quo[Xlen-2:0], 1'b1};
      end else begin
        rem <= {rem[Xlen-2:0], quo[Xlen-1]};
        quo <= {quo[Xlen-2:0], 1'b0};
      end
    end
    if (state == ST_MUL) prod <= (2*Xlen+2)'($signed(sa) * $signed(sb));
    if (state == ST_DONE) result <= res_w;
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == ST_DONE);
    end
  end
endmodule

@@ hdl/rv32m_multiply_divide_unit.sv @@
// top level of the rv32m multiply/divide unit
// depends on rv32m_pkg, rv32m_front, rv32m_back, assert_macros.svh
//
// usage: drive func, operand_a, operand_b with start high; the word is
// taken at a clock edge where start is high and busy is low
// a front stage classifies each word into a two-entry queue; the back
// end runs one word at a time
// done rises once a word has left the queue and passed the back end's
// ST_MUL and ST_DONE states (multiplies) or its bit-serial ST_DIV loop and
// ST_DONE (divides and remainders); the back end takes no new word until idle
// busy rises only when the queue is full, so two words can be queued
// while the back end works
// result is valid for exactly one cycle with done high; the receiver
// cannot stall, so it must capture result on that cycle
// reset (rst, synchronous) empties the queue and returns the back end
// to idle; results in flight are dropped
`include "assert_macros.svh"
module rv32m_multiply_divide_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 func,
  input  logic [rv32m_pkg::Xlen-1:0] operand_a,
  input  logic [rv32m_pkg::Xlen-1:0] operand_b,
  output logic                       done,
  output logic [rv32m_pkg::Xlen-1:0] result
);
  import rv32m_pkg::*;

  logic q_valid, pop;
  cmd_t q_head;

  // front end and queue
  rv32m_front u_front (
    .clk, .rst, .start, .func, .operand_a, .operand_b, .busy,
    .pop, .q_valid, .q_head
  );

  // execution back end
  rv32m_back u_back (
    .clk, .rst, .q_valid, .q_head, .pop, .done, .result
  );

  `ASSERT_IMPLIES(a_pop_needs_data, clk, rst, pop, q_valid)
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `ASSERT_NEXT(a_pop_no_done, clk, rst, pop, !done)
endmodule

@@ sim/rv32m_multiply_divide_unit_tb.sv @@
// testbench for the rv32m multiply/divide unit: directed and random words
// checked against an in-bench model of the rv32m operations
// depends on rv32m_pkg and the rtl of rv32m_multiply_divide_unit
module rv32m_multiply_divide_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rv32m_pkg::*;

  localparam int WatchLimit = 4000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  logic [2:0]      func = '0;
  logic [Xlen-1:0] operand_a = '0;
  logic [Xlen-1:0] operand_b = '0;
  logic            done;
  logic [Xlen-1:0] result;

  // expected rd values, oldest first
  logic [Xlen-1:0] rd_queue[$];
  int unsigned     mismatches = 0;
  int unsigned     words_sent = 0;
  int unsigned     words_checked = 0;
  int unsigned     idle_pct = 0;
  int unsigned     quiet_cycles = 0;

  rv32m_multiply_divide_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .operand_a(operand_a), .operand_b(operand_b), .done(done), .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [Xlen-1:0] rv32m_value(op_t op, logic [Xlen-1:0] a,
                                                  logic [Xlen-1:0] b);
    logic signed [63:0] sa, sb;
    logic [63:0]        prod;
    logic [Xlen-1:0]    ma, mb, q, r;
    sa = {{32{a[31]}}, a};
    sb = {{32{b[31]}}, b};
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    case (op)
      OP_MUL:    prod = a * b;
      OP_MULH:   prod = sa * sb;
      OP_MULHSU: prod = sa * $signed({32'd0, b});
      default:   prod = {32'd0, a} * {32'd0, b};
    endcase
    case (op)
      OP_MUL:                     return prod[31:0];
      OP_MULH, OP_MULHSU, OP_MULHU: return prod[63:32];
      OP_DIV: begin
        if (b == 0) return '1;
        if (a == 32'h8000_0000 && b == '1) return 32'h8000_0000;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
      end
      OP_DIVU:   return (b == 0) ? '1 : a / b;
      OP_REM: begin
        if (b == 0) return a;
        if (a == 32'h8000_0000 && b == '1) return '0;
        r = ma % mb;
        return a[31] ? -r : r;
      end
      default:   return (b == 0) ? a : a % b;
    endcase
  endfunction

  // sends one word, waiting for busy low at a rising edge
  task automatic send_word(op_t op, logic [Xlen-1:0] a, logic [Xlen-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    func <= op;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy);
    rd_queue.push_back(rv32m_value(op, a, b));
    words_sent++;
    @(negedge clk);
  endtask

  // result checker and watchdog, both sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (done) begin
        if (rd_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", result);
        end else begin
          if (result !== rd_queue[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %h actual %h", rd_queue[0], result);
          end
          void'(rd_queue.pop_front());
          words_checked++;
        end
      end
      if (quiet_cycles >= WatchLimit) begin
        $display("watchdog timeout with %0d words outstanding", rd_queue.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [Xlen-1:0] rand_operand();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(15);
      5: return -$urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // every op on all-ones operands, then corner operands: zero divisor, signed overflow, signs
  task automatic test_directed();
    idle_pct = 0;
    for (int i = 0; i < 8; i++) send_word(op_t'(i), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(OP_REM, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(OP_DIV, 32'd1234, 32'd0);
    send_word(OP_DIVU, 32'd1234, 32'd0);
    send_word(OP_REM, 32'hDEAD_BEEF, 32'd0);
    send_word(OP_REMU, 32'hDEAD_BEEF, 32'd0);
    send_word(OP_DIV, -32'd7, 32'd2);
    send_word(OP_REM, -32'd7, 32'd2);
    send_word(OP_DIV, 32'd7, -32'd2);
    send_word(OP_REM, 32'd7, -32'd2);
    send_word(OP_MULH, 32'h8000_0000, 32'h8000_0000);
    send_word(OP_MULHSU, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(OP_MULHU, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_MUL, 32'h0, 32'h0);
    send_word(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
  endtask

  task automatic test_random(int unsigned count, int unsigned pct);
    idle_pct = pct;
    repeat (count) send_word(op_t'($urandom_range(7)), rand_operand(), rand_operand());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(250, 0);
    test_random(150, 81);
    test_random(150, 30);
    test_random(150, 0);
    start <= 1'b0;
    while (rd_queue.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("sent %0d words over all eight ops, %0d results checked", words_sent,
             words_checked);
    $display("phases: back to back, sparse and moderate sender idling");
    if (mismatches == 0 && rd_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/rv32m_pkg.sv
hdl/rv32m_front.sv
hdl/rv32m_back.sv
hdl/rv32m_multiply_divide_unit.sv
sim/rv32m_multiply_divide_unit_tb.sv
